// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at the rising edge, off while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked at the rising edge, off while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/mexp_pkg.sv -----
// Package with the types, constants and helpers of the modular exponentiation unit.
`default_nettype none

package mexp_pkg;

    localparam int unsigned WIDTH   = 32;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] t_word;

    localparam t_word WORD_ONE = t_word'(1);

    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] power_mod;
        logic               zero_modulus_error;
    } t_out;

    // Command to the shared modular multiplier.
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mm_cmd;

    // Response from the shared modular multiplier.
    typedef struct packed {
        logic  done;
        t_word product;
    } t_mm_rsp;

    // Takes a field into the operand width: zero extend, then keep the low bits.
    function automatic t_word field_to_word(input logic [FIELD_W-1:0] f);
        logic [FIELD_W+WIDTH-1:0] ext;
        ext = {{WIDTH{1'b0}}, f};
        return ext[WIDTH-1:0];
    endfunction

    // Puts an operand-width value into a result field.
    function automatic logic [FIELD_W-1:0] word_to_field(input t_word w);
        logic [FIELD_W+WIDTH-1:0] ext;
        ext = {{FIELD_W{1'b0}}, w};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mexp_mulmod.sv -----
// Iterative modular multiplier: one operand bit per cycle, most significant first.
`default_nettype none

module mexp_mulmod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mexp_pkg::t_mm_cmd i_cmd,
    output mexp_pkg::t_mm_rsp      o_rsp
);

    localparam int unsigned SUM_W = mexp_pkg::WIDTH + 3;

    logic                       r_busy;
    logic                       r_done;
    logic [mexp_pkg::CNT_W-1:0] r_cnt;
    mexp_pkg::t_word            r_acc;
    mexp_pkg::t_word            r_a;
    mexp_pkg::t_word            r_b;
    mexp_pkg::t_word            r_m;

    logic [SUM_W-1:0] s_sum;
    logic [SUM_W-1:0] s_d1;
    logic [SUM_W-1:0] s_d2;
    mexp_pkg::t_word  n_acc;

    // 2*acc + bit*a stays below 3*m, so one of three candidates is in range.
    always_comb begin
        s_sum = {2'b00, r_acc, 1'b0}
              + (r_b[mexp_pkg::WIDTH-1] ? {3'b000, r_a} : {SUM_W{1'b0}});
        s_d1  = s_sum - {3'b000, r_m};
        s_d2  = s_sum - {2'b00, r_m, 1'b0};
        if (!s_d2[SUM_W-1]) begin
            n_acc = s_d2[mexp_pkg::WIDTH-1:0];
        end else if (!s_d1[SUM_W-1]) begin
            n_acc = s_d1[mexp_pkg::WIDTH-1:0];
        end else begin
            n_acc = s_sum[mexp_pkg::WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
                r_acc  <= '0;
                r_a    <= i_cmd.a;
                r_b    <= i_cmd.b;
                r_m    <= i_cmd.m;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// ----- rtl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit: sequencer, result register and checks.
//
// Each transfer on the input channel brings a base, an exponent and a modulus and produces
// exactly one transfer on the output channel with base^exponent mod modulus. A zero modulus
// sets zero_modulus_error and gives a result of 0; a base that is a multiple of the modulus
// (including any base with a modulus of one) gives 0 even for a zero exponent, and a zero
// exponent with any other base gives 1. The unit works on one item at a time and is ready
// for a new one only while its sequencer is idle. All arithmetic runs on one shared modular
// multiplier that retires one multiplier bit per cycle. An item first reduces the base (one
// multiplication by one), then scans the exponent from its least significant bit: one
// multiplication for each set bit and one squaring for each bit below the highest set bit.
// With L the bit length and P the number of set bits of a nonzero exponent, an item whose
// base does not reduce to zero runs L + P multiplications in all. A zero exponent or a base
// that reduces to zero stops after the reduction, and a zero or one modulus goes straight to
// the result. The output register holds a finished result until it is taken, and the next
// item can be accepted while that result still waits.
`default_nettype none

`include "assert_macros.svh"

module modular_exponentiation_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mexp_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mexp_pkg::t_out      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SQR,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic              r_start, n_start;
    mexp_pkg::t_word   r_op_a, n_op_a;
    mexp_pkg::t_word   r_op_b, n_op_b;
    mexp_pkg::t_word   r_mod, n_mod;
    mexp_pkg::t_word   r_exp, n_exp;
    mexp_pkg::t_word   r_base, n_base;
    mexp_pkg::t_word   r_res, n_res;
    logic              r_err, n_err;
    logic              r_out_valid, n_out_valid;
    mexp_pkg::t_out    r_out, n_out;

    logic              s_accept;
    mexp_pkg::t_word   s_base_in;
    mexp_pkg::t_word   s_exp_in;
    mexp_pkg::t_word   s_mod_in;
    mexp_pkg::t_word   s_exp_next;
    mexp_pkg::t_mm_cmd s_cmd;
    mexp_pkg::t_mm_rsp s_rsp;
    logic              s_in_op;
    logic              s_err_out;
    logic              s_zero_mod_acc;

    // The shared multiplier: every reduction, multiplication and squaring goes through it.
    assign s_cmd.start = r_start;
    assign s_cmd.a     = r_op_a;
    assign s_cmd.b     = r_op_b;
    assign s_cmd.m     = r_mod;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .o_rsp   (s_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign s_accept    = i_in_valid && o_in_ready;
    assign s_base_in   = mexp_pkg::field_to_word(i_in_data.base_value);
    assign s_exp_in    = mexp_pkg::field_to_word(i_in_data.exponent);
    assign s_mod_in    = mexp_pkg::field_to_word(i_in_data.modulus);
    assign s_exp_next  = r_exp >> 1;

    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_op_a      = r_op_a;
        n_op_b      = r_op_b;
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_base      = r_base;
        n_res       = r_res;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // A waiting result leaves on its output transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_exp = s_exp_in;
                    n_mod = s_mod_in;
                    n_err = 1'b0;
                    n_res = '0;
                    if (s_mod_in == '0) begin
                        // Zero modulus is flagged and answered with 0.
                        n_err   = 1'b1;
                        n_state = S_FINISH;
                    end else if (s_mod_in == mexp_pkg::WORD_ONE) begin
                        // Everything reduces to 0 modulo one.
                        n_state = S_FINISH;
                    end else begin
                        // Reduce the base as 1 * base mod m.
                        n_start = 1'b1;
                        n_op_a  = mexp_pkg::WORD_ONE;
                        n_op_b  = s_base_in;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (s_rsp.done) begin
                    n_base = s_rsp.product;
                    if (s_rsp.product == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_res = mexp_pkg::WORD_ONE;
                        if (r_exp == '0) begin
                            n_state = S_FINISH;
                        end else if (r_exp[0]) begin
                            n_start = 1'b1;
                            n_op_a  = mexp_pkg::WORD_ONE;
                            n_op_b  = s_rsp.product;
                            n_state = S_MUL;
                        end else begin
                            n_start = 1'b1;
                            n_op_a  = s_rsp.product;
                            n_op_b  = s_rsp.product;
                            n_state = S_SQR;
                        end
                    end
                end
            end
            S_MUL: begin
                if (s_rsp.done) begin
                    n_res = s_rsp.product;
                    // The last set bit needs no further squaring.
                    if (s_exp_next == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_start = 1'b1;
                        n_op_a  = r_base;
                        n_op_b  = r_base;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (s_rsp.done) begin
                    // A squaring retires the current exponent bit; more bits remain.
                    n_base  = s_rsp.product;
                    n_exp   = s_exp_next;
                    n_start = 1'b1;
                    n_op_b  = s_rsp.product;
                    if (s_exp_next[0]) begin
                        n_op_a  = r_res;
                        n_state = S_MUL;
                    end else begin
                        n_op_a  = s_rsp.product;
                        n_state = S_SQR;
                    end
                end
            end
            S_FINISH: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                  = 1'b1;
                    n_out.power_mod              = mexp_pkg::word_to_field(r_res);
                    n_out.zero_modulus_error     = r_err;
                    n_state                      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_op_a      <= n_op_a;
            r_op_b      <= n_op_b;
            r_mod       <= n_mod;
            r_exp       <= n_exp;
            r_base      <= n_base;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign s_in_op        = (r_state == S_REDUCE) || (r_state == S_MUL) || (r_state == S_SQR);
    assign s_err_out      = o_out_valid && o_out_data.zero_modulus_error;
    assign s_zero_mod_acc = s_accept && (s_mod_in == '0);

    // An error result always carries a zero power.
    `ASSERT_IMP(a_err_zero, i_clk, i_rst_n, s_err_out, o_out_data.power_mod == '0)
    // The multiplier only finishes while the sequencer is waiting on it.
    `ASSERT_IMP(a_done_in_op, i_clk, i_rst_n, s_rsp.done, s_in_op)
    // A zero modulus goes straight to the result with the error set.
    `ASSERT_NXT(a_zero_mod, i_clk, i_rst_n, s_zero_mod_acc, r_state == S_FINISH && r_err)

endmodule

`default_nettype wire
